@@ hw/rtl/whf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the weighted histogram fill unit.
// No dependencies.
package whf_pkg;

  localparam int MAX_BINS_DEF     = 1024;
  localparam int VALUE_WIDTH_DEF  = 32;
  localparam int WEIGHT_WIDTH_DEF = 16;
  localparam int SUM_WIDTH_DEF    = 48;
  localparam int FILL_WIDTH       = 32;
  localparam int BIN_COUNT_WIDTH  = 11;
  localparam int BIN_WIDTH_WIDTH  = 31;
  localparam int OP_WIDTH         = 2;
  localparam int INDEX_WIDTH      = 16;
  localparam int OUTCOME_WIDTH    = 2;
  localparam int FOUND_WIDTH      = 10;
  localparam int CFG_ADDR_WIDTH   = 3;

  localparam logic [OP_WIDTH-1:0] OP_FILL_VALUE = 2'd0;
  localparam logic [OP_WIDTH-1:0] OP_FILL_BIN   = 2'd1;
  localparam logic [OP_WIDTH-1:0] OP_READ_BIN   = 2'd2;
  localparam logic [OP_WIDTH-1:0] OP_WRITE_EDGE = 2'd3;

  localparam logic [OUTCOME_WIDTH-1:0] OUT_IN_RANGE  = 2'd0;
  localparam logic [OUTCOME_WIDTH-1:0] OUT_UNDERFLOW = 2'd1;
  localparam logic [OUTCOME_WIDTH-1:0] OUT_OVERFLOW  = 2'd2;
  localparam logic [OUTCOME_WIDTH-1:0] OUT_NO_FILL   = 2'd3;

  localparam logic [CFG_ADDR_WIDTH-1:0] REG_BIN_COUNT = 3'd0;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_RANGE_MIN = 3'd1;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_RANGE_MAX = 3'd2;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_BIN_WIDTH = 3'd3;
  localparam logic [CFG_ADDR_WIDTH-1:0] REG_VAR_EDGES = 3'd4;

  // Controller to datapath commands.
  typedef struct packed {
    logic start;      // latch item, classify
    logic clear_step; // clear one bin, advance clear pointer
    logic div_step;   // one quotient bit
    logic srch_issue; // read edge at mid
    logic srch_step;  // compare read edge, narrow window
    logic bin_read;   // read bin memory at chosen bin
    logic bin_write;  // write updated bin
    logic load_out;   // load result registers, update sums
  } whf_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clear_done;
    logic div_done;
    logic srch_done;
    logic need_div;
    logic need_srch;
    logic need_bin;
  } whf_sts_t;

endpackage

@@ hw/rtl/whf_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the weighted histogram fill unit: registers, divider, edge search, memories.
// Depends on whf_pkg.
module whf_datapath #(
  parameter int MAX_BINS     = whf_pkg::MAX_BINS_DEF,
  parameter int VALUE_WIDTH  = whf_pkg::VALUE_WIDTH_DEF,
  parameter int WEIGHT_WIDTH = whf_pkg::WEIGHT_WIDTH_DEF,
  parameter int SUM_WIDTH    = whf_pkg::SUM_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  whf_pkg::whf_cmd_t                    cmd,
  output whf_pkg::whf_sts_t                    sts,
  input  logic                                 cfg_valid,
  input  logic [whf_pkg::CFG_ADDR_WIDTH-1:0]   cfg_index,
  input  logic [63:0]                          cfg_data,
  input  logic [whf_pkg::OP_WIDTH-1:0]         op,
  input  logic signed [VALUE_WIDTH-1:0]        sample_value,
  input  logic signed [whf_pkg::INDEX_WIDTH-1:0] bin_index,
  input  logic [WEIGHT_WIDTH-1:0]              weight,
  output logic [whf_pkg::OUTCOME_WIDTH-1:0]    outcome,
  output logic [whf_pkg::FOUND_WIDTH-1:0]      bin_found,
  output logic [SUM_WIDTH-1:0]                 bin_content,
  output logic [SUM_WIDTH-1:0]                 underflow_sum,
  output logic [SUM_WIDTH-1:0]                 overflow_sum,
  output logic [SUM_WIDTH-1:0]                 in_range_sum,
  output logic [whf_pkg::FILL_WIDTH-1:0]       fill_total
);

  localparam int BW = $clog2(MAX_BINS);        // bin index bits
  localparam int EW = $clog2(MAX_BINS + 1);    // edge slot bits, also holds MAX_BINS
  localparam int NW = BW + 1;                  // bin count bits
  localparam int VW = VALUE_WIDTH;
  localparam int DW = VW + 1;                  // range difference bits
  localparam int QW = DW;
  localparam int IW = whf_pkg::INDEX_WIDTH;
  localparam int CW = whf_pkg::BIN_COUNT_WIDTH;
  localparam int WW = whf_pkg::BIN_WIDTH_WIDTH;
  localparam int FW = whf_pkg::FILL_WIDTH;
  localparam int OW = whf_pkg::FOUND_WIDTH;
  localparam logic [SUM_WIDTH-1:0] SUM_TOP = '1;
  localparam logic [FW-1:0] FILL_TOP = '1;

  // Configuration registers.
  logic [CW-1:0]        bin_count;
  logic signed [VW-1:0] range_min;
  logic signed [VW-1:0] range_max;
  logic [WW-1:0]        bin_width;
  logic                 variable_edges;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_count      <= CW'(1024);
      range_min      <= '0;
      range_max      <= VW'(1024);
      bin_width      <= WW'(1);
      variable_edges <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        whf_pkg::REG_BIN_COUNT: bin_count      <= cfg_data[CW-1:0];
        whf_pkg::REG_RANGE_MIN: range_min      <= cfg_data[VW-1:0];
        whf_pkg::REG_RANGE_MAX: range_max      <= cfg_data[VW-1:0];
        whf_pkg::REG_BIN_WIDTH: bin_width      <= cfg_data[WW-1:0];
        whf_pkg::REG_VAR_EDGES: variable_edges <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Bins in use, clamped to 1..MAX_BINS.
  logic [NW-1:0] n_use;
  always_comb begin
    if (bin_count == '0) n_use = NW'(1);
    else if (32'(bin_count) > 32'(MAX_BINS))
      n_use = NW'(MAX_BINS);
    else n_use = NW'(bin_count);
  end

  // Latched item.
  logic [whf_pkg::OP_WIDTH-1:0] op_q;
  logic signed [VW-1:0]         x_q;
  logic [WEIGHT_WIDTH-1:0]      w_q;
  logic [whf_pkg::OUTCOME_WIDTH-1:0] cls;
  logic [BW-1:0]                bin_sel;
  logic                         bin_ok;  // bin memory used by this item

  // Classification of a new item.
  logic                 idx_neg;
  logic                 idx_in;
  logic                 idx_edge_ok;
  logic [whf_pkg::OUTCOME_WIDTH-1:0] cls_new;
  always_comb begin
    idx_neg     = bin_index[IW-1];
    idx_in      = !idx_neg && ((IW + NW)'($unsigned(bin_index)) < (IW + NW)'(n_use));
    idx_edge_ok = !idx_neg && ((IW + EW)'($unsigned(bin_index)) <= (IW + EW)'(MAX_BINS));
    cls_new     = whf_pkg::OUT_NO_FILL;
    if (op == whf_pkg::OP_FILL_VALUE) begin
      if (sample_value >= range_max)      cls_new = whf_pkg::OUT_OVERFLOW;
      else if (sample_value < range_min)  cls_new = whf_pkg::OUT_UNDERFLOW;
      else                                cls_new = whf_pkg::OUT_IN_RANGE;
    end else if (op == whf_pkg::OP_FILL_BIN) begin
      if (idx_neg)      cls_new = whf_pkg::OUT_UNDERFLOW;
      else if (!idx_in) cls_new = whf_pkg::OUT_OVERFLOW;
      else              cls_new = whf_pkg::OUT_IN_RANGE;
    end
  end

  // Restoring divider: one quotient bit per cycle.
  logic [DW-1:0] dividend;
  logic [DW-1:0] rem;
  logic [QW-1:0] quo;
  logic [$clog2(QW+1)-1:0] div_cnt;
  logic [WW-1:0] divisor;
  logic [DW:0]   rem_shift;
  logic [DW:0]   rem_try;
  always_comb begin
    rem_shift = {rem, dividend[DW-1]};
    rem_try   = rem_shift - (DW + 1)'(divisor);
  end

  // Binary search window.
  logic [EW-1:0] lo, hi, mid;
  logic [VW-1:0] edge_rd;
  logic [VW-1:0] edge_mem [0:MAX_BINS];
  assign mid = EW'(({1'b0, lo} + {1'b0, hi}) >> 1);

  // Bin accumulator memory, cleared by a sweep after reset.
  logic [SUM_WIDTH-1:0] bin_mem [0:MAX_BINS-1];
  logic [SUM_WIDTH-1:0] bin_rd;
  logic [BW:0]          clr_ptr;

  // Edge memory write and search read.
  always_ff @(posedge clk) begin
    if (cmd.start && op == whf_pkg::OP_WRITE_EDGE && idx_edge_ok)
      edge_mem[EW'($unsigned(bin_index))] <= sample_value;
    if (cmd.srch_issue) edge_rd <= edge_mem[mid];
  end

  // Quotient clamped to last bin.
  logic [BW-1:0] div_bin;
  always_comb begin
    if (quo >= QW'(n_use)) div_bin = BW'(n_use - NW'(1));
    else                   div_bin = quo[BW-1:0];
  end

  logic [SUM_WIDTH:0] bin_add;
  assign bin_add = {1'b0, bin_rd} + (SUM_WIDTH + 1)'(w_q);

  always_ff @(posedge clk) begin
    if (cmd.clear_step) bin_mem[clr_ptr[BW-1:0]] <= '0;
    if (cmd.bin_read)   bin_rd <= bin_mem[bin_sel];
    if (cmd.bin_write && cls == whf_pkg::OUT_IN_RANGE)
      bin_mem[bin_sel] <= bin_add[SUM_WIDTH] ? SUM_TOP : bin_add[SUM_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_ptr <= '0;
    else if (cmd.clear_step) clr_ptr <= clr_ptr + (BW + 1)'(1);
  end

  // Item latch, divider and search registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_q     <= op;
      x_q      <= sample_value;
      w_q      <= weight;
      cls      <= cls_new;
      dividend <= DW'(sample_value) - DW'(range_min);
      divisor  <= (bin_width == '0) ? WW'(1) : bin_width;
      rem      <= '0;
      quo      <= '0;
      div_cnt  <= '0;
      lo       <= '0;
      hi       <= EW'(n_use);
      bin_sel  <= bin_index[BW-1:0];
      bin_ok   <= (op == whf_pkg::OP_FILL_BIN && cls_new == whf_pkg::OUT_IN_RANGE)
                  || (op == whf_pkg::OP_READ_BIN && idx_in);
    end else begin
      if (cmd.div_step) begin
        dividend <= {dividend[DW-2:0], 1'b0};
        div_cnt  <= div_cnt + ($clog2(QW+1))'(1);
        if (!rem_try[DW]) begin
          rem <= rem_try[DW-1:0];
          quo <= {quo[QW-2:0], 1'b1};
        end else begin
          rem <= rem_shift[DW-1:0];
          quo <= {quo[QW-2:0], 1'b0};
        end
      end
      if (cmd.srch_step) begin
        if ($signed(edge_rd) <= x_q) lo <= mid;
        else                         hi <= mid;
      end
      if (sts.div_done && !variable_edges && cls == whf_pkg::OUT_IN_RANGE &&
          op_q == whf_pkg::OP_FILL_VALUE) begin
        bin_sel <= div_bin;
        bin_ok  <= 1'b1;
      end
      if (sts.srch_done && variable_edges && cls == whf_pkg::OUT_IN_RANGE &&
          op_q == whf_pkg::OP_FILL_VALUE) begin
        bin_sel <= lo[BW-1:0];
        bin_ok  <= 1'b1;
      end
    end
  end

  always_comb begin
    sts.clear_done = clr_ptr[BW] || (clr_ptr == (BW + 1)'(MAX_BINS));
    sts.div_done   = (div_cnt == ($clog2(QW+1))'(QW));
    sts.srch_done  = (hi - lo) <= EW'(1);
    sts.need_div   = (op_q == whf_pkg::OP_FILL_VALUE) && (cls == whf_pkg::OUT_IN_RANGE)
                     && !variable_edges;
    sts.need_srch  = (op_q == whf_pkg::OP_FILL_VALUE) && (cls == whf_pkg::OUT_IN_RANGE)
                     && variable_edges;
    sts.need_bin   = bin_ok;
  end

  // Sums and fill counter.
  function automatic logic [SUM_WIDTH-1:0] sat_add(input logic [SUM_WIDTH-1:0] a,
                                                   input logic [WEIGHT_WIDTH-1:0] b);
    logic [SUM_WIDTH:0] s;
    s = {1'b0, a} + (SUM_WIDTH + 1)'(b);
    return s[SUM_WIDTH] ? SUM_TOP : s[SUM_WIDTH-1:0];
  endfunction

  logic is_fill_q;
  assign is_fill_q = (op_q == whf_pkg::OP_FILL_VALUE) || (op_q == whf_pkg::OP_FILL_BIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      underflow_sum <= '0;
      overflow_sum  <= '0;
      in_range_sum  <= '0;
      fill_total    <= '0;
    end else if (cmd.load_out && is_fill_q) begin
      if (fill_total != FILL_TOP) fill_total <= fill_total + FW'(1);
      case (cls)
        whf_pkg::OUT_UNDERFLOW: underflow_sum <= sat_add(underflow_sum, w_q);
        whf_pkg::OUT_OVERFLOW:  overflow_sum  <= sat_add(overflow_sum, w_q);
        default:                in_range_sum  <= sat_add(in_range_sum, w_q);
      endcase
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      outcome <= cls;
      if (bin_ok) begin
        bin_found <= OW'(bin_sel);
        if (is_fill_q)
          bin_content <= bin_add[SUM_WIDTH] ? SUM_TOP : bin_add[SUM_WIDTH-1:0];
        else
          bin_content <= bin_rd;
      end else begin
        bin_found   <= '0;
        bin_content <= '0;
      end
    end
  end

endmodule

@@ hw/rtl/whf_controller.sv @@
`timescale 1ns / 1ps
// Controller state machine of the weighted histogram fill unit.
// Depends on whf_pkg.
module whf_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              cfg_ready,
  output whf_pkg::whf_cmd_t cmd,
  input  whf_pkg::whf_sts_t sts
);

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_ROUTE = 8'b0000_0100,
    ST_DIV   = 8'b0000_1000,
    ST_SRCH  = 8'b0001_0000,
    ST_SCMP  = 8'b0010_0000,
    ST_READ  = 8'b0100_0000,
    ST_WRITE = 8'b1000_0000
  } whf_state_t;

  whf_state_t state, state_next;
  logic       out_valid_next;
  logic       accept;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE) || out_valid;
  assign cfg_ready = (state == ST_IDLE) && !out_valid;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      ST_CLEAR: begin
        if (sts.clear_done) state_next = ST_IDLE;
        else cmd.clear_step = 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.start  = 1'b1;
          state_next = ST_ROUTE;
        end
      end
      ST_ROUTE: begin
        if (sts.need_div)       state_next = ST_DIV;
        else if (sts.need_srch) state_next = ST_SRCH;
        else if (sts.need_bin)  state_next = ST_READ;
        else                    state_next = ST_WRITE;
      end
      ST_DIV: begin
        if (sts.div_done) state_next = ST_READ;
        else cmd.div_step = 1'b1;
      end
      ST_SRCH: begin
        if (sts.srch_done) state_next = ST_READ;
        else begin
          cmd.srch_issue = 1'b1;
          state_next     = ST_SCMP;
        end
      end
      ST_SCMP: begin
        cmd.srch_step = 1'b1;
        state_next    = ST_SRCH;
      end
      ST_READ: begin
        cmd.bin_read = 1'b1;
        state_next   = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.bin_write  = 1'b1;
        cmd.load_out   = 1'b1;
        out_valid_next = 1'b1;
        state_next     = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ hw/rtl/weighted_histogram_fill_unit.sv @@
`timescale 1ns / 1ps
// Weighted 1-D histogram fill unit: fill by value or bin, read bin, write edge.
// Path from acceptance to result: edge writes, misses and out-of-range fills go straight
// to the write state; in-range reads and bin fills read the bin first; uniform value
// fills run a 33-step divider and variable fills a binary edge search, then read the bin.
// One transaction at a time; the next is taken the cycle after the result leaves.
// Reset: synchronous; registers and sums clear, then a sweep clears every bin.
module weighted_histogram_fill_unit #(
  parameter int MAX_BINS     = whf_pkg::MAX_BINS_DEF,
  parameter int VALUE_WIDTH  = whf_pkg::VALUE_WIDTH_DEF,
  parameter int WEIGHT_WIDTH = whf_pkg::WEIGHT_WIDTH_DEF,
  parameter int SUM_WIDTH    = whf_pkg::SUM_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [whf_pkg::CFG_ADDR_WIDTH-1:0]     cfg_index,
  input  logic [63:0]                            cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [whf_pkg::OP_WIDTH-1:0]           op,
  input  logic signed [VALUE_WIDTH-1:0]          sample_value,
  input  logic signed [whf_pkg::INDEX_WIDTH-1:0] bin_index,
  input  logic [WEIGHT_WIDTH-1:0]                weight,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [whf_pkg::OUTCOME_WIDTH-1:0]      outcome,
  output logic [whf_pkg::FOUND_WIDTH-1:0]        bin_found,
  output logic [SUM_WIDTH-1:0]                   bin_content,
  output logic [SUM_WIDTH-1:0]                   underflow_sum,
  output logic [SUM_WIDTH-1:0]                   overflow_sum,
  output logic [SUM_WIDTH-1:0]                   in_range_sum,
  output logic [whf_pkg::FILL_WIDTH-1:0]         fill_total
);

  whf_pkg::whf_cmd_t cmd;
  whf_pkg::whf_sts_t sts;

  // Sequencing: clear sweep, accept, divide or search, read-modify-write.
  whf_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_ready (cfg_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Registers, divider, edge table, bin memory and sums.
  whf_datapath #(
    .MAX_BINS     (MAX_BINS),
    .VALUE_WIDTH  (VALUE_WIDTH),
    .WEIGHT_WIDTH (WEIGHT_WIDTH),
    .SUM_WIDTH    (SUM_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .op            (op),
    .sample_value  (sample_value),
    .bin_index     (bin_index),
    .weight        (weight),
    .outcome       (outcome),
    .bin_found     (bin_found),
    .bin_content   (bin_content),
    .underflow_sum (underflow_sum),
    .overflow_sum  (overflow_sum),
    .in_range_sum  (in_range_sum),
    .fill_total    (fill_total)
  );

endmodule
